/* rtl/tipf_pkg.sv */
// shared types and constants of the tcp ingress port filter
`timescale 1ns / 1ps

package tipf_pkg;

   // byte position within the frame, saturating at the end of the tcp header
   localparam int unsigned COUNT_W = 6;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type HDR_LIMIT = count_type'(54);

   // fixed header offsets (20-byte ipv4 header assumed)
   localparam count_type OFS_ETHER_TYPE     = count_type'(12);
   localparam count_type OFS_ETHER_TYPE_END = count_type'(13);
   localparam count_type OFS_IP_PROTOCOL    = count_type'(23);
   localparam count_type OFS_SRC_ADDR       = count_type'(26);
   localparam count_type OFS_SRC_ADDR_END   = count_type'(29);
   localparam count_type OFS_DST_ADDR       = count_type'(30);
   localparam count_type OFS_DST_ADDR_END   = count_type'(33);
   localparam count_type OFS_SRC_PORT       = count_type'(34);
   localparam count_type OFS_SRC_PORT_END   = count_type'(35);
   localparam count_type OFS_DST_PORT       = count_type'(36);
   localparam count_type OFS_DST_PORT_END   = count_type'(37);

   // minimum lengths for each header level
   localparam count_type LEN_ETH_HDR  = count_type'(14);
   localparam count_type LEN_IPV4_HDR = count_type'(34);

   localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
   localparam logic [15:0] PORT_SSH        = 16'd22;
   localparam logic [15:0] PORT_HTTP       = 16'd80;
   localparam logic [15:0] PORT_HTTPS      = 16'd443;

   // configuration register map
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_LOADED = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_PASS    = 2'd0,
      VERDICT_DROP    = 2'd1,
      VERDICT_ABORTED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port_value;
      logic [15:0] dest_port_value;
   } hdr_fields_type;

endpackage

/* rtl/tipf_capture.sv */
// byte counter and header field capture
`timescale 1ns / 1ps

module tipf_capture import tipf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     frame_byte,
   input  logic           frame_last,
   output hdr_fields_type fields_next,
   output count_type      length_next
);

   count_type      count_ff;
   count_type      count_in;
   hdr_fields_type fields_ff;
   hdr_fields_type fields_in;
   count_type      length;

   always_comb begin
      fields_in = fields_ff;
      length    = count_ff;
      if (count_ff < HDR_LIMIT) begin
         length = count_ff + count_type'(1);
         case (count_ff) inside
            [OFS_ETHER_TYPE:OFS_ETHER_TYPE_END]:
               fields_in.ether_type = {fields_ff.ether_type[7:0], frame_byte};
            OFS_IP_PROTOCOL:
               fields_in.ip_protocol = frame_byte;
            [OFS_SRC_ADDR:OFS_SRC_ADDR_END]:
               fields_in.source_address = {fields_ff.source_address[23:0], frame_byte};
            [OFS_DST_ADDR:OFS_DST_ADDR_END]:
               fields_in.dest_address = {fields_ff.dest_address[23:0], frame_byte};
            [OFS_SRC_PORT:OFS_SRC_PORT_END]:
               fields_in.source_port_value =
                  {fields_ff.source_port_value[7:0], frame_byte};
            [OFS_DST_PORT:OFS_DST_PORT_END]:
               fields_in.dest_port_value = {fields_ff.dest_port_value[7:0], frame_byte};
            default: ;
         endcase
      end
      count_in = frame_last ? '0 : length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

   // captured fields only matter once the length proves they were written
   always_ff @(posedge clock) begin
      if (advance) begin
         fields_ff <= fields_in;
      end
   end

   assign fields_next = fields_in;
   assign length_next = length;

`ifndef SYNTHESIS
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HDR_LIMIT)
      else $error("byte counter beyond header limit");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      advance && frame_last |=> count_ff == '0)
      else $error("byte counter not cleared after last byte");
`endif

endmodule

/* rtl/tipf_decide.sv */
// verdict logic and result register
`timescale 1ns / 1ps

module tipf_decide import tipf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  hdr_fields_type fields,
   input  count_type      length,
   input  logic [31:0]    protected_addr,
   input  logic           config_loaded,
   output logic           can_load,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_verdict
);

   verdict_type verdict_in;
   verdict_type verdict_ff;
   logic        valid_ff;
   logic        valid_in;
   logic        ssh_port;
   logic        web_port;

   assign ssh_port = (fields.source_port_value == PORT_SSH) ||
                     (fields.dest_port_value == PORT_SSH);
   assign web_port = (fields.dest_port_value == PORT_HTTP) ||
                     (fields.dest_port_value == PORT_HTTPS);

   always_comb begin
      if (length < LEN_ETH_HDR) begin
         verdict_in = VERDICT_DROP;
      end else if (fields.ether_type != ETHER_TYPE_IPV4) begin
         verdict_in = VERDICT_PASS;
      end else if (length < LEN_IPV4_HDR) begin
         verdict_in = VERDICT_DROP;
      end else if (fields.ip_protocol != IP_PROTO_TCP) begin
         verdict_in = VERDICT_PASS;
      end else if (length < HDR_LIMIT) begin
         verdict_in = VERDICT_DROP;
      end else if (ssh_port) begin
         verdict_in = VERDICT_PASS;
      end else if (!config_loaded) begin
         verdict_in = VERDICT_ABORTED;
      end else if (fields.dest_address == protected_addr) begin
         verdict_in = (fields.source_address == protected_addr || web_port) ?
                      VERDICT_PASS : VERDICT_DROP;
      end else begin
         verdict_in = VERDICT_PASS;
      end
   end

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

`ifndef SYNTHESIS
   a_abort_needs_no_config: assert property (@(posedge clock) disable iff (reset)
      load && verdict_in == VERDICT_ABORTED |-> !config_loaded)
      else $error("aborted verdict with configuration loaded");
`endif

endmodule

/* rtl/tcp_ingress_port_filter.sv */
// top level of the tcp ingress port filter
`timescale 1ns / 1ps

// Ethernet/IPv4/TCP port filter. Frames arrive one byte per item on the req_
// channel, with req_frame_last on the final byte, and one verdict item
// (0 pass, 1 drop, 2 aborted) leaves on the rsp_ channel for each frame. The
// block takes one byte in every clock cycle unless a stalled verdict holds it
// up: each byte goes into an input register, then updates the byte counter and
// the captured header fields, and on the last byte the verdict is worked out
// from the updated fields and lands in the result register in the same cycle
// as that update, where it is offered on the rsp_ channel. A stalled verdict
// only holds up the input when another last byte is waiting behind it. Header
// offsets assume a 20-byte ipv4 header; bytes beyond the 54th are neither
// counted nor captured. The protected address (index 0) and config_loaded
// (index 1) are written through the csr_ port; the user must write them only
// while no frame is in flight, as the block itself does not enforce it.

module tcp_ingress_port_filter import tipf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // byte items in
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_frame_byte,
   input  logic                   req_frame_last,
   // verdict items out
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_verdict,
   // configuration writes
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;
   logic        can_load;
   logic        req_fire;

   // configuration
   logic [31:0] protected_addr_ff;
   logic        config_loaded_ff;

   hdr_fields_type fields_next;
   count_type      length_next;

   // a held byte moves on unless it closes a frame while the verdict is stuck
   assign advance   = in_valid_ff && (!in_last_ff || can_load);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_frame_last;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         protected_addr_ff <= '0;
         config_loaded_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOCAL_ADDRESS: protected_addr_ff <= csr_write_data[31:0];
            CSR_CONFIG_LOADED: config_loaded_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // counter and field capture
   tipf_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .frame_byte  (in_byte_ff),
      .frame_last  (in_last_ff),
      .fields_next (fields_next),
      .length_next (length_next)
   );

   // verdict and result register
   tipf_decide u_decide (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && in_last_ff),
      .fields         (fields_next),
      .length         (length_next),
      .protected_addr (protected_addr_ff),
      .config_loaded  (config_loaded_ff),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_verdict    (rsp_verdict)
   );

`ifndef SYNTHESIS
   a_last_waits_for_slot: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid && !rsp_ready |-> !advance)
      else $error("last byte advanced over a stalled verdict");
`endif

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the tcp ingress port filter
`timescale 1ns / 1ps

module tb_top import tipf_pkg::*; ();

   // cycles with no item moving on either channel before the run is abandoned
   localparam int QUIET_LIMIT     = 3000;
   // length of the receiver hold-off in the back-pressure test
   localparam int HOLD_OFF_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_frame_byte;
   logic                   req_frame_last;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_verdict;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // own copy of the filter state and its registers
   logic [31:0] cfg_local;
   logic        cfg_loaded;
   count_type   trk_count;
   logic [15:0] trk_etype;
   logic [7:0]  trk_proto;
   logic [31:0] trk_src;
   logic [31:0] trk_dst;
   logic [15:0] trk_sport;
   logic [15:0] trk_dport;

   // verdicts owed by the block, oldest first
   verdict_type pending_verdicts[$];

   // knobs that steer the sender and the receiver
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   // tallies
   int mismatches      = 0;
   int bytes_accepted  = 0;
   int frames_judged   = 0;
   int verdicts_seen   = 0;
   int input_stalls    = 0;
   int quiet_cycles    = 0;

   tcp_ingress_port_filter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_byte   (req_frame_byte),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // verdict prediction
   // ---------------------------------------------------------------------------

   // verdict for a frame of n counted bytes, from the captured header fields
   function automatic verdict_type judge_frame(input count_type n);
      if (n < LEN_ETH_HDR) return VERDICT_DROP;
      if (trk_etype != ETHER_TYPE_IPV4) return VERDICT_PASS;
      if (n < LEN_IPV4_HDR) return VERDICT_DROP;
      if (trk_proto != IP_PROTO_TCP) return VERDICT_PASS;
      if (n < HDR_LIMIT) return VERDICT_DROP;
      // ssh is let through either way, even without an address set up
      if (trk_sport == PORT_SSH || trk_dport == PORT_SSH) return VERDICT_PASS;
      if (!cfg_loaded) return VERDICT_ABORTED;
      // tcp to the protected host: only from itself or to the web ports
      if (trk_dst == cfg_local && trk_src != cfg_local &&
          trk_dport != PORT_HTTP && trk_dport != PORT_HTTPS)
         return VERDICT_DROP;
      return VERDICT_PASS;
   endfunction

   // capture one accepted byte; the last byte of a frame owes a verdict
   function automatic void track_byte(input logic [7:0] b, input logic last);
      count_type pos;
      pos = trk_count;
      // bytes past the end of the tcp header are neither counted nor captured
      if (pos < HDR_LIMIT) begin
         if (pos == OFS_ETHER_TYPE || pos == OFS_ETHER_TYPE_END)
            trk_etype = {trk_etype[7:0], b};
         else if (pos == OFS_IP_PROTOCOL)
            trk_proto = b;
         else if (pos >= OFS_SRC_ADDR && pos <= OFS_SRC_ADDR_END)
            trk_src = {trk_src[23:0], b};
         else if (pos >= OFS_DST_ADDR && pos <= OFS_DST_ADDR_END)
            trk_dst = {trk_dst[23:0], b};
         else if (pos == OFS_SRC_PORT || pos == OFS_SRC_PORT_END)
            trk_sport = {trk_sport[7:0], b};
         else if (pos == OFS_DST_PORT || pos == OFS_DST_PORT_END)
            trk_dport = {trk_dport[7:0], b};
         trk_count = pos + count_type'(1);
      end
      if (last) begin
         pending_verdicts.push_back(judge_frame(trk_count));
         trk_count = '0;
         frames_judged++;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // monitor: everything sampled at the rising edge
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         cfg_local  = '0;
         cfg_loaded = 1'b0;
         trk_count  = '0;
         trk_etype  = '0;
         trk_proto  = '0;
         trk_src    = '0;
         trk_dst    = '0;
         trk_sport  = '0;
         trk_dport  = '0;
         pending_verdicts.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_LOCAL_ADDRESS)
               cfg_local = csr_write_data;
            else if (csr_index == CSR_CONFIG_LOADED)
               cfg_loaded = csr_write_data[0];
         end
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0d with no frame waiting", rsp_verdict));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_verdict !== want)
                  report_mismatch($sformatf("verdict %0d, expected %0d (%s)",
                                            rsp_verdict, want, want.name()));
            end
         end
         if (req_valid && req_ready) begin
            track_byte(req_frame_byte, req_frame_last);
            bytes_accepted++;
         end
         if (req_valid && !req_ready) input_stalls++;
      end
   end

   // watchdog: nothing moving for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles, %0d verdicts outstanding",
                     $realtime, QUIET_LIMIT, pending_verdicts.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: random stalls, or a long hold-off counted down here
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // sender side, always entered and left at a falling edge
   // ---------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_frame_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // frame of len bytes: header fields at their offsets, random filler elsewhere
   task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] sport, input logic [15:0] dport);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == OFS_ETHER_TYPE)
            b = etype[15:8];
         else if (i == OFS_ETHER_TYPE_END)
            b = etype[7:0];
         else if (i == OFS_IP_PROTOCOL)
            b = proto;
         else if (i >= OFS_SRC_ADDR && i <= OFS_SRC_ADDR_END)
            b = src[8 * (int'(OFS_SRC_ADDR_END) - i) +: 8];
         else if (i >= OFS_DST_ADDR && i <= OFS_DST_ADDR_END)
            b = dst[8 * (int'(OFS_DST_ADDR_END) - i) +: 8];
         else if (i == OFS_SRC_PORT)
            b = sport[15:8];
         else if (i == OFS_SRC_PORT_END)
            b = sport[7:0];
         else if (i == OFS_DST_PORT)
            b = dport[15:8];
         else if (i == OFS_DST_PORT_END)
            b = dport[7:0];
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic send_tcp(input int len, input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] sport, input logic [15:0] dport);
      send_frame(len, ETHER_TYPE_IPV4, IP_PROTO_TCP, src, dst, sport, dport);
   endtask

   // drop valid and let every owed verdict come back, plus the pipeline depth
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // registers are only touched with no frame in flight
   task automatic configure(input logic [31:0] addr, input logic [31:0] loaded_word);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LOCAL_ADDRESS;
      csr_write_data   <= addr;
      @(negedge clock);
      csr_index        <= CSR_CONFIG_LOADED;
      csr_write_data   <= loaded_word;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // one frame of a randomly chosen kind, mostly full tcp headers
   task automatic send_random_frame(output int len);
      int          kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] etype;
      logic [7:0]  proto;
      kind  = $urandom_range(0, 99);
      src   = $urandom;
      dst   = $urandom;
      sport = 16'($urandom);
      dport = 16'($urandom);
      etype = ETHER_TYPE_IPV4;
      proto = IP_PROTO_TCP;
      len   = $urandom_range(54, 60);
      if ($urandom_range(0, 99) < 60) dst = cfg_local;
      if ($urandom_range(0, 99) < 20) src = cfg_local;
      case ($urandom_range(0, 9))
         0:       sport = PORT_SSH;
         1:       dport = PORT_SSH;
         2, 3:    dport = PORT_HTTP;
         4, 5:    dport = PORT_HTTPS;
         default: ;
      endcase
      if (kind < 55) begin
         // well-formed tcp, length as chosen above
      end else if (kind < 65) begin
         proto = 8'($urandom);
         len   = $urandom_range(34, 60);
      end else if (kind < 73) begin
         etype = 16'($urandom);
         len   = $urandom_range(14, 60);
      end else if (kind < 88) begin
         // cut short somewhere inside the headers
         len = $urandom_range(1, 53);
      end else if (kind < 95) begin
         len = $urandom_range(55, 90);
      end else begin
         etype = 16'($urandom);
         proto = 8'($urandom);
         len   = $urandom_range(1, 70);
      end
      send_frame(len, etype, proto, src, dst, sport, dport);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // out of reset nothing is loaded, so checked tcp must come back aborted
   task automatic test_unconfigured;
      send_tcp(54, 32'h0A00_0001, 32'h0000_0000, 16'd1000, 16'd8080);
      send_tcp(54, 32'h0A00_0001, 32'h0000_0000, PORT_SSH, 16'd8080);
      send_frame(1, 16'h0000, 8'h00, '0, '0, '0, '0);
      // only bit 0 of the loaded register counts
      configure(32'h5A5A_A5A5, 32'hFFFF_FFFE);
      send_tcp(54, 32'h0101_0101, 32'h5A5A_A5A5, 16'd4000, 16'd80);
   endtask

   // each header level too short, and just long enough
   task automatic test_length_limits;
      configure(32'hC0A8_0001, 32'h0000_0001);
      send_tcp(13, 32'h0A00_0002, 32'hC0A8_0001, 16'd1, 16'd2);
      send_frame(14, 16'h86DD, IP_PROTO_TCP, '0, '0, '0, '0);
      send_tcp(14, 32'h0A00_0002, 32'hC0A8_0001, 16'd1, 16'd2);
      send_tcp(33, 32'h0A00_0002, 32'hC0A8_0001, 16'd1, 16'd2);
      send_frame(34, ETHER_TYPE_IPV4, 8'd17, 32'h0A00_0002, 32'hC0A8_0001, '0, '0);
      send_tcp(34, 32'h0A00_0002, 32'hC0A8_0001, 16'd1, 16'd2);
      send_tcp(53, 32'h0A00_0002, 32'hC0A8_0001, 16'd1, 16'd2);
      send_tcp(54, 32'h0A00_0002, 32'hC0A8_0002, 16'd1, 16'd2);
   endtask

   // rules for tcp aimed at the protected host, with an all-ones address
   task automatic test_local_host;
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tcp(54, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, PORT_HTTP);
      send_tcp(54, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, PORT_HTTPS);
      send_tcp(54, 32'h0000_0000, 32'hFFFF_FFFF, 16'd5000, 16'h0000);
      send_tcp(54, 32'h0000_0000, 32'hFFFF_FFFF, 16'd5000, 16'hFFFF);
      // port bytes swapped must not be taken for ssh
      send_tcp(54, 32'h1234_5678, 32'hFFFF_FFFF, 16'h1600, 16'h1600);
      send_tcp(54, 32'h1234_5678, 32'hFFFF_FFFF, PORT_SSH, 16'd9);
      send_tcp(54, 32'h1234_5678, 32'hFFFF_FFFF, 16'd9, PORT_SSH);
      send_tcp(54, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd9, 16'd9);
      send_tcp(54, 32'h1234_5678, 32'hFFFF_FFFE, 16'd9, 16'd9);
   endtask

   // tails past the tcp header must be ignored, and the count must not wrap
   task automatic test_long_frames;
      configure(32'h0000_0000, 32'h0000_0001);
      send_tcp(100, 32'h0A0B_0C0D, 32'h0000_0000, 16'd7, 16'd1234);
      send_tcp(64, 32'h0000_0000, 32'h0000_0000, 16'd7, 16'd1234);
      send_tcp(55, 32'h0A0B_0C0D, 32'h0000_0000, 16'd7, PORT_HTTPS);
      // short frame after a long one: stale fields must not count
      send_tcp(20, 32'h0A0B_0C0D, 32'h0000_0000, 16'd7, PORT_HTTPS);
      // run of single-byte frames back to back
      repeat (6) send_frame(1, 16'hFFFF, 8'hFF, '1, '1, '1, '1);
   endtask

   // random traffic under four idling patterns and register settings
   task automatic test_random_traffic;
      int phase_bytes;
      int len;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure($urandom, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
            1: configure(32'hFFFF_FFFF, 32'h0000_0001);
            2: configure(32'h0000_0000, 32'hFFFF_FFFF);
            default: configure($urandom, $urandom);
         endcase
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 40) begin
            send_random_frame(len);
            phase_bytes += len;
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // receiver holds off while bytes keep coming, so the input has to stall
   task automatic test_output_backpressure;
      configure($urandom, 32'h0000_0001);
      stall_pct = 17;
      @(posedge clock);
      hold_left = HOLD_OFF_CYCLES;
      @(negedge clock);
      repeat (40) send_frame(1, '0, '0, '0, '0, '0, '0);
      repeat (3) send_tcp(54, $urandom, cfg_local, 16'($urandom), 16'($urandom));
      stall_pct = 0;
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_frame_byte   = '0;
      req_frame_last   = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_unconfigured();
      test_length_limits();
      test_local_host();
      test_long_frames();
      test_random_traffic();
      test_output_backpressure();

      wait_drained();
      repeat (4) @(negedge clock);

      $display("covered %0d frames in %0d bytes, %0d verdicts checked",
               frames_judged, bytes_accepted, verdicts_seen);
      $display("input held back for %0d cycles, %0d mismatches", input_stalls, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tipf_pkg.sv
rtl/tipf_capture.sv
rtl/tipf_decide.sv
rtl/tcp_ingress_port_filter.sv
tb/sv/tb_top.sv
